### hw/rtl/isc_pkg.sv
package isc_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 16;

   localparam int AXIS_BITS  = 16;
   localparam int TIME_BITS  = 32;
   localparam int STEPS_BITS = 4;
   localparam int CSR_BITS   = 16;
   localparam int SUM_BITS   = 32;
   localparam int ROOT_BITS  = 16;
   localparam int ROOT_STEPS = 16;
   localparam logic [SUM_BITS-1:0] ROOT_BIT_START = 32'h4000_0000;

   localparam logic [15:0] MIN_INTERVAL_RESET   = 16'd300;
   localparam logic [15:0] MAX_INTERVAL_RESET   = 16'd2000;
   localparam logic [3:0]  VALID_RUN_RESET      = 4'd4;
   localparam logic [7:0]  WINDOW_LENGTH_RESET  = 8'd50;
   localparam logic [15:0] GYRO_MINIMUM_RESET   = 16'd400;
   localparam logic [15:0] SWING_LOW_RESET      = 16'd1500;
   localparam logic [15:0] SWING_HIGH_RESET     = 16'd30000;
   localparam logic [15:0] FALLBACK_RESET       = 16'd4000;
   localparam logic [7:0]  RUN_MAX              = 8'd255;

   typedef enum logic [2:0] {
      CSR_MIN_INTERVAL  = 3'd0,
      CSR_MAX_INTERVAL  = 3'd1,
      CSR_VALID_RUN     = 3'd2,
      CSR_WINDOW_LENGTH = 3'd3,
      CSR_GYRO_MINIMUM  = 3'd4,
      CSR_SWING_LOW     = 3'd5,
      CSR_SWING_HIGH    = 3'd6,
      CSR_FALLBACK      = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT_GO,
      ST_ROOT,
      ST_FILTER,
      ST_WINDOW,
      ST_THRESH,
      ST_CROSS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
   } root_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } root_status_type;

endpackage

### hw/rtl/integer_step_counter.sv
// Step detector: each accepted sample yields exactly one rsp transfer carrying
// the number of steps it confirmed. Each sample is worked on in turn: two
// magnitudes, each squared and summed on one shared 16x16 multiplier, then
// passed to the shared square-root unit, which is started and runs its 16
// iterations; then the filter, window, threshold and step states, and the
// load of the result. No new sample is taken before that load.
// req_stall is high while a sample is in flight; a finished result waiting on
// rsp_stall does not block the next sample until that one finishes.
module integer_step_counter
   import isc_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [AXIS_BITS-1:0] req_accel_x,
   input  logic signed [AXIS_BITS-1:0] req_accel_y,
   input  logic signed [AXIS_BITS-1:0] req_accel_z,
   input  logic signed [AXIS_BITS-1:0] req_gyro_x,
   input  logic signed [AXIS_BITS-1:0] req_gyro_y,
   input  logic signed [AXIS_BITS-1:0] req_gyro_z,
   input  logic [TIME_BITS-1:0]        req_time_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [STEPS_BITS-1:0]       rsp_confirmed,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [2:0]                  csr_index,
   input  logic [CSR_BITS-1:0]         csr_data
);

   localparam int SB = SAMPLE_BITS;
   localparam logic [SB-1:0] LevelMax = '1;

   // configuration
   logic [15:0] min_interval_ff, max_interval_ff, gyro_minimum_ff;
   logic [15:0] swing_low_ff, swing_high_ff, fallback_ff;
   logic [3:0]  valid_run_ff;
   logic [7:0]  window_length_ff;

   // sample payload
   logic signed [AXIS_BITS-1:0] ax_ff, ay_ff, az_ff, gx_ff, gy_ff, gz_ff;
   logic [TIME_BITS-1:0]        time_ff;

   // sequencer and datapath
   state_type               state_ff, state_in;
   logic                    group_ff, group_in;
   logic [1:0]              sq_cnt_ff, sq_cnt_in;
   logic [SUM_BITS-1:0]     prod_ff, prod_in;
   logic [SUM_BITS-1:0]     sum_ff, sum_in;
   logic [SB-1:0]           am_ff, am_in;
   logic [SB-1:0]           gm_ff, gm_in;
   logic                    upd_ff, upd_in;
   logic [STEPS_BITS-1:0]   res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STEPS_BITS-1:0]   rsp_steps_ff, rsp_steps_in;

   // detector state
   logic [SB-1:0]        filt_ff, filt_in;
   logic [SB-1:0]        prev_ff, prev_in;
   logic [SB-1:0]        wmax_ff, wmax_in;
   logic [SB-1:0]        wmin_ff, wmin_in;
   logic [SB-1:0]        thr_ff, thr_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic [7:0]           wcnt_ff, wcnt_in;
   logic [7:0]           run_ff, run_in;
   logic [SB-1:0]        gpeak_ff, gpeak_in;

   root_ctl_type          root_ctl;
   root_status_type       root_status;
   logic [ROOT_BITS-1:0]  root_value;

   logic signed [AXIS_BITS-1:0] axis;
   logic signed [SUM_BITS-1:0]  square;
   logic [SB-1:0]               mag;
   logic [SB+1:0]               filt_sum;
   logic [8:0]                  wcnt_next;
   logic [SB-1:0]               swing;
   logic [SB:0]                 mid;
   logic [16:0]                 fb;
   logic                        crossing;
   logic [TIME_BITS-1:0]        dt;
   logic [7:0]                  run_next;
   logic                        accept;

   isc_root u_root (
      .clock   (clock),
      .reset   (reset),
      .ctl     (root_ctl),
      .operand (sum_ff),
      .status  (root_status),
      .root    (root_value)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_confirmed = rsp_steps_ff;

   always_comb begin
      case ({group_ff, sq_cnt_ff})
         3'b000:  axis = ax_ff;
         3'b001:  axis = ay_ff;
         3'b010:  axis = az_ff;
         3'b100:  axis = gx_ff;
         3'b101:  axis = gy_ff;
         3'b110:  axis = gz_ff;
         default: axis = '0;
      endcase
   end

   assign square = axis * axis;
   assign mag = (root_value > 16'(LevelMax)) ? LevelMax : root_value[SB-1:0];

   always_comb begin
      state_in     = state_ff;
      group_in     = group_ff;
      sq_cnt_in    = sq_cnt_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      am_in        = am_ff;
      gm_in        = gm_ff;
      upd_in       = upd_ff;
      res_in       = res_ff;
      filt_in      = filt_ff;
      prev_in      = prev_ff;
      wmax_in      = wmax_ff;
      wmin_in      = wmin_ff;
      thr_in       = thr_ff;
      last_in      = last_ff;
      wcnt_in      = wcnt_ff;
      run_in       = run_ff;
      gpeak_in     = gpeak_ff;
      root_ctl     = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_steps_in = rsp_steps_ff;

      filt_sum  = (SB+2)'({filt_ff, 1'b0}) + (SB+2)'(filt_ff) + (SB+2)'(am_ff);
      wcnt_next = 9'(wcnt_ff) + 9'd1;
      swing     = (wmax_ff >= wmin_ff) ? (wmax_ff - wmin_ff) : '0;
      mid       = (SB+1)'(wmin_ff) + (SB+1)'(swing >> 1);
      fb        = 17'(wmin_ff) + 17'(fallback_ff);
      crossing  = (prev_ff < thr_ff) && (filt_ff >= thr_ff);
      dt        = time_ff - last_ff;
      run_next  = (run_ff == RUN_MAX) ? run_ff : run_ff + 8'd1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               group_in  = 1'b0;
               sq_cnt_in = '0;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (sq_cnt_ff != 2'd3) begin
               prod_in = $unsigned(square);
            end
            if (sq_cnt_ff == 2'd1) begin
               sum_in = prod_ff;
            end else if (sq_cnt_ff != 2'd0) begin
               sum_in = sum_ff + prod_ff;
            end
            sq_cnt_in = sq_cnt_ff + 2'd1;
            if (sq_cnt_ff == 2'd3) begin
               state_in = ST_ROOT_GO;
            end
         end
         ST_ROOT_GO: begin
            root_ctl.start = 1'b1;
            state_in       = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_status.done) begin
               if (!group_ff) begin
                  am_in     = mag;
                  group_in  = 1'b1;
                  sq_cnt_in = '0;
                  state_in  = ST_SQUARE;
               end else begin
                  gm_in    = mag;
                  state_in = ST_FILTER;
               end
            end
         end
         ST_FILTER: begin
            if (filt_ff == '0) begin
               filt_in = am_ff;
               prev_in = am_ff;
               thr_in  = am_ff;
               wmax_in = am_ff;
               wmin_in = am_ff;
            end else begin
               prev_in = filt_ff;
               filt_in = filt_sum[SB+1:2];
            end
            if (gm_ff > gpeak_ff) begin
               gpeak_in = gm_ff;
            end
            state_in = ST_WINDOW;
         end
         ST_WINDOW: begin
            if (wcnt_ff == '0) begin
               wmax_in = filt_ff;
               wmin_in = filt_ff;
            end else begin
               if (filt_ff > wmax_ff) wmax_in = filt_ff;
               if (filt_ff < wmin_ff) wmin_in = filt_ff;
            end
            if (wcnt_next >= 9'(window_length_ff)) begin
               upd_in  = 1'b1;
               wcnt_in = '0;
            end else begin
               upd_in  = 1'b0;
               wcnt_in = wcnt_next[7:0];
            end
            state_in = ST_THRESH;
         end
         ST_THRESH: begin
            if (upd_ff) begin
               if (16'(swing) > swing_low_ff && 16'(swing) < swing_high_ff) begin
                  thr_in = mid[SB-1:0];
               end else begin
                  thr_in = (fb > 17'(LevelMax)) ? LevelMax : fb[SB-1:0];
               end
            end
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            res_in = '0;
            if (crossing) begin
               if (16'(gpeak_ff) > gyro_minimum_ff) begin
                  if (dt >= 32'(min_interval_ff) && dt <= 32'(max_interval_ff)) begin
                     run_in  = run_next;
                     last_in = time_ff;
                     if (run_next == 8'(valid_run_ff)) begin
                        res_in = valid_run_ff;
                     end else if (run_next > 8'(valid_run_ff)) begin
                        res_in = 4'd1;
                     end
                  end else if (dt > 32'(max_interval_ff)) begin
                     run_in  = 8'd1;
                     last_in = time_ff;
                  end
               end
               gpeak_in = '0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_steps_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ax_ff   <= req_accel_x;
         ay_ff   <= req_accel_y;
         az_ff   <= req_accel_z;
         gx_ff   <= req_gyro_x;
         gy_ff   <= req_gyro_y;
         gz_ff   <= req_gyro_z;
         time_ff <= req_time_ms;
      end
      group_ff     <= group_in;
      sq_cnt_ff    <= sq_cnt_in;
      prod_ff      <= prod_in;
      sum_ff       <= sum_in;
      am_ff        <= am_in;
      gm_ff        <= gm_in;
      upd_ff       <= upd_in;
      res_ff       <= res_in;
      rsp_steps_ff <= rsp_steps_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         filt_ff      <= '0;
         prev_ff      <= '0;
         wmax_ff      <= '0;
         wmin_ff      <= '1;
         thr_ff       <= '0;
         last_ff      <= '0;
         wcnt_ff      <= '0;
         run_ff       <= '0;
         gpeak_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         filt_ff      <= filt_in;
         prev_ff      <= prev_in;
         wmax_ff      <= wmax_in;
         wmin_ff      <= wmin_in;
         thr_ff       <= thr_in;
         last_ff      <= last_in;
         wcnt_ff      <= wcnt_in;
         run_ff       <= run_in;
         gpeak_ff     <= gpeak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_interval_ff  <= MIN_INTERVAL_RESET;
         max_interval_ff  <= MAX_INTERVAL_RESET;
         valid_run_ff     <= VALID_RUN_RESET;
         window_length_ff <= WINDOW_LENGTH_RESET;
         gyro_minimum_ff  <= GYRO_MINIMUM_RESET;
         swing_low_ff     <= SWING_LOW_RESET;
         swing_high_ff    <= SWING_HIGH_RESET;
         fallback_ff      <= FALLBACK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_INTERVAL:  min_interval_ff  <= csr_data;
            CSR_MAX_INTERVAL:  max_interval_ff  <= csr_data;
            CSR_VALID_RUN:     valid_run_ff     <= csr_data[3:0];
            CSR_WINDOW_LENGTH: window_length_ff <= csr_data[7:0];
            CSR_GYRO_MINIMUM:  gyro_minimum_ff  <= csr_data;
            CSR_SWING_LOW:     swing_low_ff     <= csr_data;
            CSR_SWING_HIGH:    swing_high_ff    <= csr_data;
            CSR_FALLBACK:      fallback_ff      <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

### hw/rtl/isc_root.sv
module isc_root
   import isc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  root_ctl_type         ctl,
   input  logic [SUM_BITS-1:0]  operand,
   output root_status_type      status,
   output logic [ROOT_BITS-1:0] root
);

   localparam int CntBits = $clog2(ROOT_STEPS);

   logic [SUM_BITS-1:0] x_ff, x_in;
   logic [SUM_BITS-1:0] r_ff, r_in;
   logic [SUM_BITS-1:0] b_ff, b_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SUM_BITS-1:0] trial;

   always_comb begin
      trial   = r_ff + b_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         x_in    = operand;
         r_in    = '0;
         b_in    = ROOT_BIT_START;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in = x_ff - trial;
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in   = b_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntBits'(ROOT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      r_ff   <= r_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = r_ff[ROOT_BITS-1:0];

endmodule

### verif/step_count_checker.sv
module step_count_checker
   import isc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic signed [AXIS_BITS-1:0] req_accel_x,
   input  logic signed [AXIS_BITS-1:0] req_accel_y,
   input  logic signed [AXIS_BITS-1:0] req_accel_z,
   input  logic signed [AXIS_BITS-1:0] req_gyro_x,
   input  logic signed [AXIS_BITS-1:0] req_gyro_y,
   input  logic signed [AXIS_BITS-1:0] req_gyro_z,
   input  logic [TIME_BITS-1:0]        req_time_ms,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [STEPS_BITS-1:0]       rsp_confirmed,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [2:0]                  csr_index,
   input  logic [CSR_BITS-1:0]         csr_data,
   output int unsigned                 error_count,
   output int unsigned                 rsp_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEVEL_BITS = SAMPLE_BITS_DEFAULT;

   typedef logic [LEVEL_BITS-1:0] level_type;
   localparam level_type LEVEL_TOP = '1;

   // register copies
   logic [15:0] gap_min_ms, gap_max_ms, gyro_floor;
   logic [15:0] swing_floor, swing_ceiling, fallback_rise;
   logic [3:0]  run_needed;
   logic [7:0]  window_len;

   // detector state
   level_type   level_now, level_last, window_hi, window_lo, threshold, gyro_peak;
   logic [31:0] last_step_ms;
   logic [7:0]  window_fill, run_count;

   logic [STEPS_BITS-1:0] steps_due[$];
   logic [STEPS_BITS-1:0] wanted;
   int unsigned           mismatches = 0;
   int unsigned           responses = 0;

   function automatic level_type vector_norm(input logic signed [AXIS_BITS-1:0] a, b, c);
      longint unsigned sum, cand;
      level_type       root;
      sum  = longint'(a) * a + longint'(b) * b + longint'(c) * c;
      root = '0;
      for (int i = LEVEL_BITS - 1; i >= 0; i--) begin
         cand = root | (longint'(1) << i);
         if (cand * cand <= sum) root = level_type'(cand);
      end
      return root;
   endfunction

   function automatic logic [STEPS_BITS-1:0] detect_steps(
      input logic signed [AXIS_BITS-1:0] ax, ay, az, gx, gy, gz,
      input logic [TIME_BITS-1:0]        stamp
   );
      level_type             accel_mag, gyro_norm, swing;
      logic [31:0]           gap, level_sum;
      logic [LEVEL_BITS:0]   candidate;
      logic [STEPS_BITS-1:0] found;
      found     = '0;
      accel_mag = vector_norm(ax, ay, az);
      gyro_norm = vector_norm(gx, gy, gz);

      if (level_now == '0) begin
         level_now = accel_mag;
         threshold = accel_mag;
         window_hi = accel_mag;
         window_lo = accel_mag;
      end
      level_last = level_now;
      level_sum  = 32'(level_now) * 3 + 32'(accel_mag);
      level_now  = level_type'(level_sum / 4);

      if (gyro_norm > gyro_peak) gyro_peak = gyro_norm;

      if (window_fill == '0) begin
         window_hi = level_now;
         window_lo = level_now;
      end else begin
         if (level_now > window_hi) window_hi = level_now;
         if (level_now < window_lo) window_lo = level_now;
      end

      window_fill++;
      if (window_fill >= window_len) begin
         swing = (window_hi >= window_lo) ? window_hi - window_lo : '0;
         if (swing > swing_floor && swing < swing_ceiling)
            candidate = (LEVEL_BITS+1)'(window_lo) + (LEVEL_BITS+1)'(swing / 2);
         else
            candidate = (LEVEL_BITS+1)'(window_lo) + (LEVEL_BITS+1)'(fallback_rise);
         threshold   = (candidate > (LEVEL_BITS+1)'(LEVEL_TOP)) ? LEVEL_TOP
                                                                : level_type'(candidate);
         window_fill = '0;
      end

      if (level_last < threshold && level_now >= threshold) begin
         gap = stamp - last_step_ms;
         if (gyro_peak > gyro_floor) begin
            if (gap >= 32'(gap_min_ms) && gap <= 32'(gap_max_ms)) begin
               if (run_count < RUN_MAX) run_count++;
               last_step_ms = stamp;
               if (run_count == 8'(run_needed))
                  found = STEPS_BITS'(run_needed);
               else if (run_count > 8'(run_needed))
                  found = STEPS_BITS'(1);
            end else if (gap > 32'(gap_max_ms)) begin
               run_count    = 8'd1;
               last_step_ms = stamp;
            end
         end
         gyro_peak = '0;
      end
      return found;
   endfunction

   task automatic flag_error(input string what);
      $display("%0t step check: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gap_min_ms    = MIN_INTERVAL_RESET;
         gap_max_ms    = MAX_INTERVAL_RESET;
         run_needed    = VALID_RUN_RESET;
         window_len    = WINDOW_LENGTH_RESET;
         gyro_floor    = GYRO_MINIMUM_RESET;
         swing_floor   = SWING_LOW_RESET;
         swing_ceiling = SWING_HIGH_RESET;
         fallback_rise = FALLBACK_RESET;
         level_now     = '0;
         level_last    = '0;
         window_hi     = '0;
         window_lo     = '1;
         threshold     = '0;
         last_step_ms  = '0;
         window_fill   = '0;
         run_count     = '0;
         gyro_peak     = '0;
         steps_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_MIN_INTERVAL:  gap_min_ms    = csr_data;
               CSR_MAX_INTERVAL:  gap_max_ms    = csr_data;
               CSR_VALID_RUN:     run_needed    = csr_data[3:0];
               CSR_WINDOW_LENGTH: window_len    = csr_data[7:0];
               CSR_GYRO_MINIMUM:  gyro_floor    = csr_data;
               CSR_SWING_LOW:     swing_floor   = csr_data;
               CSR_SWING_HIGH:    swing_ceiling = csr_data;
               CSR_FALLBACK:      fallback_rise = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            responses++;
            if (steps_due.size() == 0) begin
               flag_error($sformatf("result with nothing pending, steps=%0d",
                                    rsp_confirmed));
            end else begin
               wanted = steps_due.pop_front();
               if (rsp_confirmed !== wanted)
                  flag_error($sformatf("steps=%0d, predicted %0d",
                                       rsp_confirmed, wanted));
            end
         end
         if (req_valid && !req_stall)
            steps_due.push_back(detect_steps(req_accel_x, req_accel_y, req_accel_z,
                                             req_gyro_x, req_gyro_y, req_gyro_z,
                                             req_time_ms));
      end
      error_count <= mismatches;
      rsp_count   <= responses;
   end

endmodule

### verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import isc_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int IDLE_PCT      = 38;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 4000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [AXIS_BITS-1:0] req_accel_x = '0;
   logic signed [AXIS_BITS-1:0] req_accel_y = '0;
   logic signed [AXIS_BITS-1:0] req_accel_z = '0;
   logic signed [AXIS_BITS-1:0] req_gyro_x = '0;
   logic signed [AXIS_BITS-1:0] req_gyro_y = '0;
   logic signed [AXIS_BITS-1:0] req_gyro_z = '0;
   logic [TIME_BITS-1:0]        req_time_ms = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [STEPS_BITS-1:0]       rsp_confirmed;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [2:0]                  csr_index = '0;
   logic [CSR_BITS-1:0]         csr_data = '0;

   int unsigned error_count;
   int unsigned rsp_count;
   int unsigned sent_items = 0;
   int unsigned quiet_cycles = 0;
   int          gap_pct = IDLE_PCT;
   int          stall_pct = IDLE_PCT;
   int          holds_asked = 0;
   int          holds_done = 0;
   logic [31:0] now_ms = '0;
   logic        moved;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   integer_step_counter dut (.*);

   step_count_checker u_check (.*);

   assign moved = (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                  (csr_valid && csr_ready);

   always @(posedge clock) begin
      if (reset || moved) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, plus long hold-offs on request
   initial begin
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_sample(input logic signed [AXIS_BITS-1:0] ax, ay, az, gx, gy, gz,
                              input logic [TIME_BITS-1:0] stamp);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      req_gyro_x  <= gx;
      req_gyro_y  <= gy;
      req_gyro_z  <= gz;
      req_time_ms <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_BITS-1:0] min_gap, max_gap, run_len,
                                 win_len, gyro_min, swing_lo, swing_hi, offset);
      write_csr(CSR_MIN_INTERVAL, min_gap);
      write_csr(CSR_MAX_INTERVAL, max_gap);
      write_csr(CSR_VALID_RUN, run_len);
      write_csr(CSR_WINDOW_LENGTH, win_len);
      write_csr(CSR_GYRO_MINIMUM, gyro_min);
      write_csr(CSR_SWING_LOW, swing_lo);
      write_csr(CSR_SWING_HIGH, swing_hi);
      write_csr(CSR_FALLBACK, offset);
      csr_valid <= 1'b0;
   endtask

   // wait for every result, then let the pipeline drain
   task automatic settle();
      req_valid <= 1'b0;
      while (rsp_count < sent_items) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly walking bursts (triangle wave on one accel axis), some junk samples
   task automatic mixed_traffic(input int unsigned count);
      int unsigned done_n, len, period, step_ms, amp, gyro_amp, ph, slope_pos, axis;
      int          base, val;
      logic        flip;
      logic signed [AXIS_BITS-1:0] acc [3];
      logic signed [AXIS_BITS-1:0] gyr [3];
      done_n = 0;
      while (done_n < count) begin
         if ($urandom_range(9) < 2) begin
            len = $urandom_range(4, 1);
            if (len > count - done_n) len = count - done_n;
            repeat (len) begin
               case ($urandom_range(3))
                  0:       now_ms = $urandom();
                  1:       now_ms += $urandom_range(5000);
                  default: now_ms += $urandom_range(40);
               endcase
               send_sample(16'($urandom()), 16'($urandom()), 16'($urandom()),
                           16'($urandom()), 16'($urandom()), 16'($urandom()), now_ms);
            end
         end else begin
            len      = $urandom_range(60, 16);
            if (len > count - done_n) len = count - done_n;
            period   = $urandom_range(40, 4);
            step_ms  = ($urandom_range(3) == 0) ? $urandom_range(700, 1)
                                                : $urandom_range(60, 15);
            base     = $urandom_range(32000);
            amp      = $urandom_range(24000);
            gyro_amp = ($urandom_range(3) == 0) ? $urandom_range(500)
                                                : $urandom_range(32767);
            axis     = $urandom_range(2);
            flip     = $urandom_range(1);
            if ($urandom_range(7) == 0) now_ms = 32'hFFFF_FFFF - $urandom_range(2000);
            for (int k = 0; k < len; k++) begin
               ph        = k % period;
               slope_pos = (ph < period / 2) ? ph : period - ph;
               val       = base - int'(amp / 2) + int'(amp * slope_pos * 2 / period);
               if (val < 0) val = 0;
               if (val > 32767) val = 32767;
               if (flip) val = -val;
               for (int j = 0; j < 3; j++) begin
                  acc[j] = (j == axis) ? 16'(val) : 16'(int'($urandom_range(4000)) - 2000);
                  gyr[j] = 16'(int'($urandom_range(2 * gyro_amp)) - int'(gyro_amp));
               end
               now_ms += step_ms + $urandom_range(step_ms / 8);
               send_sample(acc[0], acc[1], acc[2], gyr[0], gyr[1], gyr[2], now_ms);
            end
         end
         done_n += len;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // all-zero sample keeps the filter unseeded, next one seeds it
      send_sample('0, '0, '0, '0, '0, '0, '0);
      now_ms = 32'd50;
      send_sample('0, '0, 16'sd8000, 16'sd900, '0, '0, now_ms);
      // four clean strides, the last one releases the run
      for (int c = 0; c < 4; c++) begin
         repeat (3) begin
            now_ms += 100;
            send_sample('0, '0, 16'sd1000, '0, 16'sd700, '0, now_ms);
         end
         repeat (2) begin
            now_ms += 100;
            send_sample(16'sd300, '0, 16'sd30000, '0, '0, -16'sd700, now_ms);
         end
      end
      send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  32'hFFFF_FFFF);
      send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, '0);
      send_sample(16'sh8000, 16'sh7FFF, '0, 16'sd1, -16'sd1, '0, 32'd100);
      settle();

      // reset values again, upper bits set to check masking
      apply_settings(MIN_INTERVAL_RESET, MAX_INTERVAL_RESET, 16'h5A00 | VALID_RUN_RESET,
                     16'h3C00 | WINDOW_LENGTH_RESET, GYRO_MINIMUM_RESET, SWING_LOW_RESET,
                     SWING_HIGH_RESET, FALLBACK_RESET);
      gap_pct   = 0;
      stall_pct = 0;
      mixed_traffic(20);
      gap_pct   = IDLE_PCT;
      stall_pct = IDLE_PCT;
      holds_asked++;
      mixed_traffic(25);
      settle();

      // zero run and window, saturating fallback threshold
      apply_settings(16'd0, 16'hFFFF, 16'hFFF0, 16'hAB00, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
      mixed_traffic(20);
      settle();

      apply_settings(16'hFFFF, 16'hFFFF, 16'h000F, 16'h00FF, 16'hFFFF, 16'hFFFF, 16'h0000,
                     16'h0000);
      mixed_traffic(15);
      settle();

      apply_settings(16'd1000, 16'd1200, 16'd2, 16'd20, 16'd200, 16'd800, 16'd20000,
                     16'd2500);
      mixed_traffic(20);

      repeat (2) begin
         settle();
         apply_settings(16'($urandom_range(600)), 16'($urandom_range(3000, 200)),
                        16'($urandom()), {8'($urandom()), 8'($urandom_range(60))},
                        16'($urandom_range(2000)), 16'($urandom_range(5000)),
                        16'($urandom()), 16'($urandom()));
         mixed_traffic(25);
      end
      settle();

      // steady ramp: a step on every sample, long enough to saturate the run
      apply_settings(16'd0, 16'hFFFF, 16'(1 + $urandom_range(14)), 16'd1, 16'd0, 16'd0,
                     16'd0, 16'd0);
      for (int v = 300; v <= 32700; v += 100) begin
         now_ms += 10;
         send_sample(16'(v), 16'(v), 16'(v), 16'sd9000, '0, '0, now_ms);
      end
      settle();

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
